FILE: rtl/fat12_chain_table_generator_top_assert.svh
// Assertion macros shared by the checker of the FAT12 table generator.
`ifndef FAT12_CHAIN_TABLE_GENERATOR_TOP_ASSERT_SVH
`define FAT12_CHAIN_TABLE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define F12CTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define F12CTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/f12ctg_pkg.sv
`default_nettype none

package f12ctg_pkg;

    // Fixed geometry of the synthesised volume.
    localparam int unsigned MAX_ENTRIES      = 768;
    localparam int unsigned TOTAL_SECTORS    = 4096;
    localparam int unsigned FAT_SECTOR_COUNT = 12;
    localparam int unsigned SECTOR_SIZE      = 512;

    localparam logic [9:0]  FILE_LIMIT       = 10'(MAX_ENTRIES);
    localparam logic [4:0]  FAT_SECTOR_LIMIT = 5'(FAT_SECTOR_COUNT);
    localparam logic [16:0] LAST_CLUSTER     = 17'(TOTAL_SECTORS - FAT_SECTOR_COUNT - 1);

    localparam logic [11:0] MEDIA_ENTRY   = 12'hFF8;
    localparam logic [11:0] CHAIN_END     = 12'hFFF;
    localparam logic [11:0] FIRST_DATA_CL = 12'd2;

    // Round-up constant for the cluster count of a file.
    localparam logic [24:0] SECTOR_ROUND = 25'(SECTOR_SIZE - 1);

    // Reciprocal of three, exact for dividends below 2**16.
    localparam logic [15:0] RECIP3       = 16'hAAAB;
    localparam int unsigned RECIP3_SHIFT = 17;

    // Chain-end bitmap memory: one bit per cluster.
    localparam int unsigned MAP_WIDTH = 64;
    localparam int unsigned MAP_DEPTH = 64;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic rem;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: rtl/f12ctg_ram.sv
`default_nettype none

module f12ctg_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/f12ctg_ctrl.sv
`default_nettype none

module f12ctg_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      f12ctg_pkg::t_dp_cmd o_cmd
);

    f12ctg_pkg::t_state r_state;
    f12ctg_pkg::t_state n_state;
    logic               r_out_valid;
    logic               n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= f12ctg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            f12ctg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = f12ctg_pkg::S_CALC;
                end
            end
            f12ctg_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = f12ctg_pkg::S_READ;
            end
            f12ctg_pkg::S_READ: begin
                o_cmd.rem = 1'b1;
                n_state   = f12ctg_pkg::S_DONE;
            end
            f12ctg_pkg::S_DONE: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = f12ctg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = f12ctg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/f12ctg_dp.sv
`default_nettype none

module f12ctg_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire f12ctg_pkg::t_dp_cmd i_cmd,
    input  wire logic [1:0]          i_action,
    input  wire logic [23:0]         i_file_size,
    input  wire logic [3:0]          i_fat_sector,
    input  wire logic [8:0]          i_byte_index,
    output      logic [5:0]          o_map_raddr,
    input  wire logic [63:0]         i_map_rdata,
    output      logic                o_map_we,
    output      logic [5:0]          o_map_waddr,
    output      logic [63:0]         o_map_wdata,
    output      logic [7:0]          o_data_byte,
    output      logic [11:0]         o_first_cluster,
    output      logic [11:0]         o_cluster_count,
    output      logic [1:0]          o_status
);

    localparam int unsigned RECIP3_TOP = f12ctg_pkg::RECIP3_SHIFT + 10;

    // Captured item.
    logic [1:0]  r_action;
    logic [23:0] r_size;
    logic [3:0]  r_sector;
    logic [8:0]  r_bidx;

    // Derived values.
    logic [10:0] r_g;
    logic [15:0] r_n;
    logic [1:0]  r_rem;

    // Allocator state.
    logic [11:0] r_nfc;
    logic [9:0]  r_files;
    logic [63:0] r_row_vld;

    // Result register.
    logic [7:0]  r_data_byte;
    logic [11:0] r_first;
    logic [11:0] r_count;
    logic [1:0]  r_status;

    logic [12:0] w_off;
    logic [28:0] w_prod;
    logic [24:0] w_round;
    logic [12:0] w_g3;
    logic [16:0] w_last;
    logic [5:0]  w_row;
    logic [63:0] w_word;
    logic [11:0] w_e_lo;
    logic [11:0] w_e_hi;
    logic [11:0] w_lo;
    logic [11:0] w_hi;
    logic        w_full;
    logic        w_fits;
    logic        w_alloc;

    logic [7:0]  n_data_byte;
    logic [11:0] n_first;
    logic [11:0] n_count;
    logic [1:0]  n_status;

    // A FAT sector is 512 bytes, so the byte offset is a plain concatenation.
    assign w_off   = {r_sector, r_bidx};
    assign w_prod  = w_off * f12ctg_pkg::RECIP3;
    assign w_round = {1'b0, r_size} + f12ctg_pkg::SECTOR_ROUND;
    assign w_g3    = {2'b00, r_g} + {1'b0, r_g, 1'b0};
    assign w_last  = {5'd0, r_nfc} + {1'b0, r_n} - 17'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_size   <= i_file_size;
            r_sector <= i_fat_sector;
            r_bidx   <= i_byte_index;
        end
        if (i_cmd.calc) begin
            r_g <= w_prod[RECIP3_TOP:f12ctg_pkg::RECIP3_SHIFT];
            r_n <= w_round[24:9];
        end
        if (i_cmd.rem) begin
            r_rem <= 2'(w_off - w_g3);
        end
    end

    // Reads need the word holding entries 2g and 2g+1; adds need the word of the last cluster.
    assign w_row       = (r_action == f12ctg_pkg::ACT_ADD) ? w_last[11:6] : r_g[10:5];
    assign o_map_raddr = w_row;
    assign w_word      = r_row_vld[w_row] ? i_map_rdata : 64'd0;

    function automatic logic [11:0] entry_value(input logic [11:0] e,
                                                input logic [11:0] nfc,
                                                input logic [63:0] word);
        if (e == 12'd0) begin
            entry_value = f12ctg_pkg::MEDIA_ENTRY;
        end else if (e == 12'd1) begin
            entry_value = f12ctg_pkg::CHAIN_END;
        end else if (e < nfc) begin
            entry_value = word[e[5:0]] ? f12ctg_pkg::CHAIN_END : e + 12'd1;
        end else begin
            entry_value = 12'd0;
        end
    endfunction

    assign w_e_lo = {r_g, 1'b0};
    assign w_e_hi = {r_g, 1'b1};
    assign w_lo   = entry_value(w_e_lo, r_nfc, w_word);
    assign w_hi   = entry_value(w_e_hi, r_nfc, w_word);

    assign w_full  = (r_files >= f12ctg_pkg::FILE_LIMIT);
    assign w_fits  = (w_last <= f12ctg_pkg::LAST_CLUSTER);
    assign w_alloc = (r_action == f12ctg_pkg::ACT_ADD) && !w_full && (r_n != 16'd0) && w_fits;

    always_comb begin
        n_data_byte = 8'd0;
        n_first     = 12'd0;
        n_count     = 12'd0;
        n_status    = f12ctg_pkg::ST_OK;
        case (r_action)
            f12ctg_pkg::ACT_ADD: begin
                if (w_full) begin
                    n_status = f12ctg_pkg::ST_FULL;
                end else if (r_n != 16'd0) begin
                    if (w_fits) begin
                        n_first = r_nfc;
                        n_count = r_n[11:0];
                    end else begin
                        n_status = f12ctg_pkg::ST_NOSPACE;
                    end
                end
            end
            f12ctg_pkg::ACT_READ: begin
                if ({1'b0, r_sector} < f12ctg_pkg::FAT_SECTOR_LIMIT) begin
                    case (r_rem)
                        2'd0:    n_data_byte = w_lo[7:0];
                        2'd1:    n_data_byte = {w_hi[3:0], w_lo[11:8]};
                        default: n_data_byte = w_hi[11:4];
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfc     <= f12ctg_pkg::FIRST_DATA_CL;
            r_files   <= 10'd0;
            r_row_vld <= 64'd0;
        end else if (i_cmd.commit) begin
            if (r_action == f12ctg_pkg::ACT_CLEAR) begin
                r_nfc     <= f12ctg_pkg::FIRST_DATA_CL;
                r_files   <= 10'd0;
                r_row_vld <= 64'd0;
            end else if ((r_action == f12ctg_pkg::ACT_ADD) && !w_full) begin
                r_files <= r_files + 10'd1;
                if (w_alloc) begin
                    r_nfc               <= w_last[11:0] + 12'd1;
                    r_row_vld[w_row]    <= 1'b1;
                end
            end
        end
    end

    assign o_map_we    = i_cmd.commit && w_alloc;
    assign o_map_waddr = w_row;
    assign o_map_wdata = w_word | (64'd1 << w_last[5:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_data_byte <= n_data_byte;
            r_first     <= n_first;
            r_count     <= n_count;
            r_status    <= n_status;
        end
    end

    assign o_data_byte     = r_data_byte;
    assign o_first_cluster = r_first;
    assign o_cluster_count = r_count;
    assign o_status        = r_status;

endmodule

`default_nettype wire

FILE: rtl/fat12_chain_table_generator_top.sv
`default_nettype none

// FAT12 allocation table generator. Each word on the input side is a clear, an
// add, a read or the unused action code, and gives exactly one result word. Every
// item passes through four steps: capture, a reciprocal multiply that finds the
// entry pair of the FAT byte offset (and rounds the file size up to clusters), one
// registered read of the 64-bit chain-end bitmap memory, in which the byte phase
// is also found, and a commit that writes the bitmap back for an add that gets
// clusters and loads the output register. The next word is taken only after the
// item before it has left its commit step, so items are worked one at a time. A
// clear passes through the same steps, because per-row valid flags empty the
// bitmap at once. The input side is ready again while a result still waits in the
// output register; the next item then holds in its commit step until that result
// has been taken.
module fat12_chain_table_generator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [23:0] i_file_size,
    input  wire logic [3:0]  i_fat_sector,
    input  wire logic [8:0]  i_byte_index,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_data_byte,
    output      logic [11:0] o_first_cluster,
    output      logic [11:0] o_cluster_count,
    output      logic [1:0]  o_status
);

    f12ctg_pkg::t_dp_cmd w_cmd;
    logic [5:0]          w_map_raddr;
    logic [63:0]         w_map_rdata;
    logic                w_map_we;
    logic [5:0]          w_map_waddr;
    logic [63:0]         w_map_wdata;

    f12ctg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (w_cmd)
    );

    f12ctg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_action),
        .i_file_size     (i_file_size),
        .i_fat_sector    (i_fat_sector),
        .i_byte_index    (i_byte_index),
        .o_map_raddr     (w_map_raddr),
        .i_map_rdata     (w_map_rdata),
        .o_map_we        (w_map_we),
        .o_map_waddr     (w_map_waddr),
        .o_map_wdata     (w_map_wdata),
        .o_data_byte     (o_data_byte),
        .o_first_cluster (o_first_cluster),
        .o_cluster_count (o_cluster_count),
        .o_status        (o_status)
    );

    f12ctg_ram #(
        .WIDTH (f12ctg_pkg::MAP_WIDTH),
        .DEPTH (f12ctg_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

endmodule

`default_nettype wire

FILE: rtl/f12ctg_chk.sv
`default_nettype none

`include "fat12_chain_table_generator_top_assert.svh"

module f12ctg_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_action,
    input wire logic [23:0] i_file_size,
    input wire logic [3:0]  i_fat_sector,
    input wire logic [8:0]  i_byte_index,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_data_byte,
    input wire logic [11:0] o_first_cluster,
    input wire logic [11:0] o_cluster_count,
    input wire logic [1:0]  o_status
);

    // A result word is held until it is taken.
    `F12CTG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")

    // Items are worked one at a time: no input is taken in the cycle after one is.
    `F12CTG_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input taken early")

    // A rejected or dropped add gets no clusters.
    `F12CTG_ASSERT_NOW(a_fail_no_run, i_clk, i_rst_n, o_valid && (o_status != f12ctg_pkg::ST_OK), (o_first_cluster == 12'd0) && (o_cluster_count == 12'd0), "failed add has a run")

    // A granted run starts at a data cluster.
    `F12CTG_ASSERT_NOW(a_run_start, i_clk, i_rst_n, o_valid && (o_cluster_count != 12'd0), o_first_cluster >= f12ctg_pkg::FIRST_DATA_CL, "run starts too low")

    // A byte of the table never shows together with add results.
    `F12CTG_ASSERT_NOW(a_byte_alone, i_clk, i_rst_n, o_valid && (o_data_byte != 8'd0), (o_cluster_count == 12'd0) && (o_status == f12ctg_pkg::ST_OK), "read byte mixed")

endmodule

bind fat12_chain_table_generator_top f12ctg_chk u_f12ctg_chk (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         LAST_DATA_CL = f12ctg_pkg::TOTAL_SECTORS
                                          - f12ctg_pkg::FAT_SECTOR_COUNT - 1;
    localparam int         SECT_BYTES   = f12ctg_pkg::SECTOR_SIZE;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [1:0]  action;
        logic [23:0] file_size;
        logic [3:0]  fat_sector;
        logic [8:0]  byte_index;
    } t_fat_cmd;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] first_cluster;
        logic [11:0] cluster_count;
        logic [1:0]  status;
    } t_fat_reply;

    typedef struct {
        t_fat_cmd   cmd;
        bit         typed;
        t_fat_reply reply;
    } t_fat_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [23:0] i_file_size;
    logic [3:0]  i_fat_sector;
    logic [8:0]  i_byte_index;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_data_byte;
    logic [11:0] o_first_cluster;
    logic [11:0] o_cluster_count;
    logic [1:0]  o_status;

    // Shadow of the allocation state, advanced as each word is accepted.
    int          alloc_next_free;
    int          alloc_files;
    logic [63:0] chain_end_map [64];

    t_fat_reply  reply_q [$];
    t_fat_row    directed_rows [$];
    t_fat_reply  seen_reply;
    t_fat_reply  want_reply;
    int          mismatch_cnt;
    int          words_sent;
    int          cycle_cnt;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_req;

    fat12_chain_table_generator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_file_size     (i_file_size),
        .i_fat_sector    (i_fat_sector),
        .i_byte_index    (i_byte_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_data_byte     (o_data_byte),
        .o_first_cluster (o_first_cluster),
        .o_cluster_count (o_cluster_count),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_alloc_table();
        alloc_next_free = f12ctg_pkg::FIRST_DATA_CL;
        alloc_files     = 0;
        for (int i = 0; i < 64; i++) chain_end_map[i] = '0;
    endfunction

    function automatic logic [11:0] fat_entry_value(int e);
        e = e & 'hFFF;
        if (e == 0) return f12ctg_pkg::MEDIA_ENTRY;
        if (e == 1) return f12ctg_pkg::CHAIN_END;
        if (e < alloc_next_free) begin
            if (chain_end_map[e >> 6][e & 63]) return f12ctg_pkg::CHAIN_END;
            return 12'(e + 1);
        end
        return 12'd0;
    endfunction

    function automatic t_fat_reply fat_reply_for(t_fat_cmd cmd);
        t_fat_reply  rsp;
        int          n;
        int          last;
        int          off;
        int          g;
        logic [11:0] lo;
        logic [11:0] hi;
        rsp = '0;
        case (cmd.action)
            f12ctg_pkg::ACT_CLEAR: clear_alloc_table();
            f12ctg_pkg::ACT_ADD: begin
                if (alloc_files >= f12ctg_pkg::MAX_ENTRIES) begin
                    rsp.status = f12ctg_pkg::ST_FULL;
                end else begin
                    n = (int'(cmd.file_size) + SECT_BYTES - 1) / SECT_BYTES;
                    alloc_files++;
                    if (n != 0) begin
                        last = alloc_next_free + n - 1;
                        if (last > LAST_DATA_CL) begin
                            rsp.status = f12ctg_pkg::ST_NOSPACE;
                        end else begin
                            rsp.first_cluster = 12'(alloc_next_free);
                            rsp.cluster_count = 12'(n);
                            chain_end_map[last >> 6][last & 63] = 1'b1;
                            alloc_next_free = (last + 1) & 'hFFF;
                        end
                    end
                end
            end
            f12ctg_pkg::ACT_READ: begin
                if (cmd.fat_sector < f12ctg_pkg::FAT_SECTOR_COUNT) begin
                    off = int'(cmd.fat_sector) * SECT_BYTES + int'(cmd.byte_index);
                    g   = off / 3;
                    lo  = fat_entry_value(2 * g);
                    hi  = fat_entry_value(2 * g + 1);
                    // Two 12-bit entries are packed little-endian into three bytes.
                    case (off % 3)
                        0: rsp.data_byte = lo[7:0];
                        1: rsp.data_byte = {hi[3:0], lo[11:8]};
                        default: rsp.data_byte = hi[11:4];
                    endcase
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic t_fat_cmd random_cmd();
        t_fat_cmd cmd;
        cmd.action     = 2'($urandom);
        cmd.file_size  = 24'($urandom);
        cmd.fat_sector = 4'($urandom);
        cmd.byte_index = 9'($urandom);
        return cmd;
    endfunction

    // A read aimed at the entries around the allocated region.
    function automatic t_fat_cmd aim_read(t_fat_cmd cmd);
        int e;
        int off;
        e   = $urandom_range(0, alloc_next_free + 3);
        off = 3 * (e / 2) + $urandom_range(0, 2);
        cmd.action     = f12ctg_pkg::ACT_READ;
        cmd.fat_sector = 4'(off / SECT_BYTES);
        cmd.byte_index = 9'(off % SECT_BYTES);
        return cmd;
    endfunction

    function automatic logic [23:0] pick_file_size(int max_size);
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'(SECT_BYTES * $urandom_range(1, max_size / SECT_BYTES));
            2: return 24'($urandom_range(1, SECT_BYTES));
            default: return 24'($urandom_range(1, max_size));
        endcase
    endfunction

    task automatic add_row(input logic [1:0] action, input logic [23:0] size,
                           input logic [3:0] sector, input logic [8:0] bidx,
                           input bit typed, input logic [7:0] data,
                           input logic [11:0] first, input logic [11:0] count,
                           input logic [1:0] status);
        t_fat_row row;
        row.cmd   = '{action, size, sector, bidx};
        row.typed = typed;
        row.reply = '{data, first, count, status};
        directed_rows.push_back(row);
    endtask

    task automatic send_word(input t_fat_cmd cmd, input bit typed,
                             input t_fat_reply typed_reply);
        t_fat_reply want;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= cmd.action;
        i_file_size  <= cmd.file_size;
        i_fat_sector <= cmd.fat_sector;
        i_byte_index <= cmd.byte_index;
        do @(posedge i_clk); while (!o_ready);
        want = fat_reply_for(cmd);
        if (typed) want = typed_reply;
        reply_q.push_back(want);
        words_sent++;
    endtask

    task automatic drain_replies();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_episode();
        t_fat_cmd cmd;
        int       len;
        int       pick;
        len = $urandom_range(4, 30);
        if ($urandom_range(9) < 3) begin
            cmd = random_cmd();
            cmd.action = f12ctg_pkg::ACT_CLEAR;
            send_word(cmd, 1'b0, '0);
        end
        repeat (len) begin
            cmd  = random_cmd();
            pick = $urandom_range(99);
            if (pick < 45) begin
                cmd.action    = f12ctg_pkg::ACT_ADD;
                cmd.file_size = pick_file_size(8192);
            end else if (pick < 90) begin
                cmd = aim_read(cmd);
            end else begin
                // Odd words: the unused action, stray reads, huge files, clears.
                case ($urandom_range(3))
                    0: cmd.action = ACT_UNUSED;
                    1: cmd.action = f12ctg_pkg::ACT_READ;
                    2: cmd.action = f12ctg_pkg::ACT_ADD;
                    default: cmd.action = f12ctg_pkg::ACT_CLEAR;
                endcase
            end
            send_word(cmd, 1'b0, '0);
        end
    endtask

    // Runs the file table from empty to full, then knocks on it a few more times.
    task automatic fill_file_table();
        t_fat_cmd cmd;
        int       extra;
        cmd = random_cmd();
        cmd.action = f12ctg_pkg::ACT_CLEAR;
        send_word(cmd, 1'b0, '0);
        extra = 0;
        while (extra < 8) begin
            if (alloc_files >= f12ctg_pkg::MAX_ENTRIES) extra++;
            cmd = random_cmd();
            if ($urandom_range(99) < 85) begin
                cmd.action    = f12ctg_pkg::ACT_ADD;
                cmd.file_size = pick_file_size(2600);
            end else begin
                cmd = aim_read(cmd);
            end
            send_word(cmd, 1'b0, '0);
        end
    endtask

    task automatic note_mismatch(input string why, input t_fat_reply want,
                                 input t_fat_reply got);
        if (mismatch_cnt < 10) begin
            $display("%s at %0t: expected data %02h first %03h count %03h status %0d",
                     why, $realtime, want.data_byte, want.first_cluster,
                     want.cluster_count, want.status);
            $display("    got data %02h first %03h count %03h status %0d",
                     got.data_byte, got.first_cluster, got.cluster_count,
                     got.status);
        end
        mismatch_cnt++;
    endtask

    // Receiver: random stalls, or a long hold-off when asked for one.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_reply = '{o_data_byte, o_first_cluster, o_cluster_count, o_status};
            if (reply_q.size() == 0) begin
                note_mismatch("Unexpected word", '0, seen_reply);
            end else begin
                want_reply = reply_q.pop_front();
                if (seen_reply.data_byte !== want_reply.data_byte
                        || seen_reply.first_cluster !== want_reply.first_cluster
                        || seen_reply.cluster_count !== want_reply.cluster_count
                        || seen_reply.status !== want_reply.status)
                    note_mismatch("Wrong word", want_reply, seen_reply);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out with %0d words outstanding.", reply_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = f12ctg_pkg::ACT_CLEAR;
        i_file_size  = '0;
        i_fat_sector = '0;
        i_byte_index = '0;
        hold_req     = 1'b0;
        mismatch_cnt = 0;
        words_sent   = 0;
        cycle_cnt    = 0;
        snd_idle_pct = 37;
        rcv_idle_pct = 48;
        clear_alloc_table();

        // Header bytes, a few small files, edge reads, overflow and a clear.
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd0, 1,
                8'hF8, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd1, 1,
                8'hFF, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd2, 1,
                8'hFF, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd3, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_ADD, 24'd0, 4'hF, 9'h1FF, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_ADD, 24'd1, 4'd0, 9'd0, 1,
                8'h00, 12'd2, 12'd1, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_ADD, 24'd512, 4'd0, 9'd0, 1,
                8'h00, 12'd3, 12'd1, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_ADD, 24'd513, 4'd0, 9'd0, 1,
                8'h00, 12'd4, 12'd2, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd3, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd4, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd5, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd6, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd11, 9'd511, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'hFFFFFF, 4'd12, 9'd0, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd15, 9'd511, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(ACT_UNUSED, 24'hFFFFFF, 4'hF, 9'h1FF, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_ADD, 24'hFFFFFF, 4'd0, 9'd0, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_NOSPACE);
        add_row(f12ctg_pkg::ACT_ADD, 24'd2087936, 4'd0, 9'd0, 1,
                8'h00, 12'd6, 12'd4078, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_ADD, 24'd1, 4'd0, 9'd0, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_NOSPACE);
        add_row(f12ctg_pkg::ACT_ADD, 24'd0, 4'd0, 9'd0, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd11, 9'd491, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd11, 9'd492, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd11, 9'd493, 0,
                '0, '0, '0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_CLEAR, 24'hFFFFFF, 4'hF, 9'h1FF, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);
        add_row(f12ctg_pkg::ACT_READ, 24'd0, 4'd0, 9'd3, 1,
                8'h00, 12'd0, 12'd0, f12ctg_pkg::ST_OK);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].reply);
        drain_replies();

        // The receiver stops for a long while so that the block backs up.
        hold_req = 1'b1;
        while (words_sent < 525) run_episode();
        drain_replies();

        snd_idle_pct = 48;
        rcv_idle_pct = 37;
        fill_file_table();
        while (words_sent < 1325) run_episode();
        drain_replies();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        while (words_sent < 1825) run_episode();
        drain_replies();

        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && reply_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/f12ctg_pkg.sv
rtl/f12ctg_ram.sv
rtl/f12ctg_ctrl.sv
rtl/f12ctg_dp.sv
rtl/fat12_chain_table_generator_top.sv
rtl/f12ctg_chk.sv
tb/tb.sv
